>>> sv/ttl_pkg.sv
// Package for the transition table lookup block.
// Holds the table size, derived widths, function and status codes and the
// slot write bundle. No dependencies.
`default_nettype none

package ttl_pkg;

   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = IDX_W + 1;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [15:0]      wr_event;
      logic [15:0]      wr_target;
      logic             cnt_inc;
      logic             cnt_dec;
   } slot_wr_type;

endpackage

`default_nettype wire

>>> sv/ttl_if.sv
// Channel interfaces of the transition table lookup block: request,
// response and control register write. Depends on nothing.
`default_nettype none

interface ttl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] event_code;
   logic [15:0] target_state;

   modport source (output valid, output func, output event_code,
                   output target_state, input ready);
   modport sink   (input valid, input func, input event_code,
                   input target_state, output ready);
endinterface

interface ttl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_state;
   logic [1:0]  status;

   modport source (output valid, output next_state, output status, input ready);
   modport sink   (input valid, input next_state, input status, output ready);
endinterface

interface ttl_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] own_state_id;

   modport source (output valid, output own_state_id, input ready);
   modport sink   (input valid, input own_state_id, output ready);
endinterface

`default_nettype wire

>>> sv/ttl_slot_store.sv
// Slot storage of the transition table: event and target arrays with a fill
// count. Depends on ttl_pkg.
`default_nettype none

module ttl_slot_store (
   input  wire                     clock,
   input  wire                     reset,
   input  wire [ttl_pkg::IDX_W-1:0] rd_idx,
   input  wire ttl_pkg::slot_wr_type wr,
   output logic [15:0]             rd_event,
   output logic [15:0]             rd_target,
   output logic [ttl_pkg::CNT_W-1:0] count
);
   import ttl_pkg::*;

   logic [15:0]      event_mem [SLOTS];
   logic [15:0]      target_mem [SLOTS];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Slots at or above the fill count are empty and their target reads as zero.
   always_comb begin
      rd_event  = event_mem[rd_idx];
      rd_target = (CNT_W'(rd_idx) < count_ff) ? target_mem[rd_idx] : 16'd0;
      count     = count_ff;
      count_in  = count_ff;
      if (wr.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (wr.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         event_mem[wr.wr_idx]  <= wr.wr_event;
         target_mem[wr.wr_idx] <= wr.wr_target;
      end
   end

endmodule

`default_nettype wire

>>> sv/ttl_seq.sv
// Sequencer of the transition table: scans one slot per cycle through a
// shared compare, shifts slots down on delete and holds the response word.
// Depends on ttl_pkg and the channel interfaces.
`default_nettype none

module ttl_seq (
   input  wire                        clock,
   input  wire                        reset,
   ttl_req_if.sink                    req_chan,
   ttl_rsp_if.source                  rsp_chan,
   input  wire [15:0]                 own_state_id,
   output logic [ttl_pkg::IDX_W-1:0]  rd_idx,
   input  wire [15:0]                 rd_event,
   input  wire [15:0]                 rd_target,
   input  wire [ttl_pkg::CNT_W-1:0]   count,
   output ttl_pkg::slot_wr_type       wr
);
   import ttl_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [1:0]       func_ff, func_in;
   logic [15:0]      event_ff, event_in;
   logic [15:0]      target_ff, target_in;
   logic [15:0]      res_next_ff, res_next_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_next_ff, rsp_next_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0] scan_nx;
   logic             scan_end;
   logic [15:0]      cmp_a;
   logic [15:0]      cmp_b;
   logic             cmp_eq;

   assign scan_nx  = scan_ff + CNT_W'(1);
   assign scan_end = (scan_ff == CNT_W'(SLOTS));

   // The one equality compare, shared by lookup and delete.
   assign cmp_a  = (func_ff == FUNC_LOOKUP) ? rd_event : rd_target;
   assign cmp_b  = (func_ff == FUNC_LOOKUP) ? event_ff : target_ff;
   assign cmp_eq = (cmp_a == cmp_b);

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.next_state = rsp_next_ff;
   assign rsp_chan.status     = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      func_in       = func_ff;
      event_in      = event_ff;
      target_in     = target_ff;
      res_next_in   = res_next_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_next_in   = rsp_next_ff;
      rsp_status_in = rsp_status_ff;
      rd_idx        = scan_ff[IDX_W-1:0];
      wr            = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in       = req_chan.func;
               event_in      = req_chan.event_code;
               target_in     = req_chan.target_state;
               scan_in       = '0;
               res_next_in   = 16'd0;
               res_status_in = STATUS_DONE;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            case (func_ff)
               FUNC_LOOKUP: begin
                  if (scan_end || rd_target == 16'd0) begin
                     res_next_in = own_state_id;
                     state_in    = S_DONE;
                  end else if (cmp_eq) begin
                     res_next_in = rd_target;
                     state_in    = S_DONE;
                  end else begin
                     scan_in = scan_nx;
                  end
               end
               FUNC_ADD: begin
                  if (count == CNT_W'(SLOTS)) begin
                     res_status_in = STATUS_FULL;
                  end else if (target_ff != 16'd0) begin
                     wr.wr_en     = 1'b1;
                     wr.wr_idx    = count[IDX_W-1:0];
                     wr.wr_event  = event_ff;
                     wr.wr_target = target_ff;
                     wr.cnt_inc   = 1'b1;
                  end
                  state_in = S_DONE;
               end
               FUNC_DELETE: begin
                  if (scan_end) begin
                     res_status_in = STATUS_NOT_FOUND;
                     state_in      = S_DONE;
                  end else if (cmp_eq) begin
                     // A zero target matches the first empty slot and changes nothing.
                     state_in = (rd_target == 16'd0) ? S_DONE : S_SHIFT;
                  end else begin
                     scan_in = scan_nx;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            rd_idx = scan_nx[IDX_W-1:0];
            if (scan_nx < count) begin
               wr.wr_en     = 1'b1;
               wr.wr_idx    = scan_ff[IDX_W-1:0];
               wr.wr_event  = rd_event;
               wr.wr_target = rd_target;
               scan_in      = scan_nx;
            end else begin
               wr.cnt_dec = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_next_in   = res_next_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      func_ff       <= func_in;
      event_ff      <= event_in;
      target_ff     <= target_in;
      res_next_ff   <= res_next_in;
      res_status_ff <= res_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

>>> sv/transition_table_lookup_top.sv
// Top level of the transition table lookup block.
// Depends on ttl_pkg, the channel interfaces, ttl_slot_store and ttl_seq.
//
// The request channel carries one word per operation: a lookup of an event,
// an add of an event and target pair, or a delete of a target. The response
// channel returns one word per request with the next state and a status.
// The control register channel writes the state's own id, which a lookup
// returns when no transition matches; it is always ready. The user must
// write it only while no request is in flight, and the block does not
// enforce it. A lookup or delete scans one slot per cycle through a
// single shared compare. A delete that finds a nonzero target then
// shifts each later slot down by one. The sequencer works on one request
// at a time and the request channel is ready only while it is idle, so
// the next request is accepted at the earliest in the same cycle as the
// response turns valid. The response sits in an output register; if the
// receiver stalls, the next request may still be accepted and worked on,
// and its result waits until the register frees. Reset empties the table
// and clears the own id to zero.
`default_nettype none

module transition_table_lookup_top (
   input  wire       clock,
   input  wire       reset,
   ttl_req_if.sink   req_chan,
   ttl_rsp_if.source rsp_chan,
   ttl_csr_if.sink   csr_chan
);
   import ttl_pkg::*;

   logic [15:0]      own_id_ff;
   logic [15:0]      own_id_in;
   logic [IDX_W-1:0] rd_idx;
   logic [15:0]      rd_event;
   logic [15:0]      rd_target;
   logic [CNT_W-1:0] count;
   slot_wr_type      wr;

   assign csr_chan.ready = 1'b1;
   assign own_id_in = csr_chan.valid ? csr_chan.own_state_id : own_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 16'd0;
      end else begin
         own_id_ff <= own_id_in;
      end
   end

   ttl_slot_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .wr        (wr),
      .rd_event  (rd_event),
      .rd_target (rd_target),
      .count     (count)
   );

   ttl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .own_state_id (own_id_ff),
      .rd_idx       (rd_idx),
      .rd_event     (rd_event),
      .rd_target    (rd_target),
      .count        (count),
      .wr           (wr)
   );

endmodule

`default_nettype wire
